FILE: rtl/udtmr_pkg.sv
// Shared types, constants and command codes of the up/down seconds timer.
package udtmr_pkg;

    // Timing
    localparam int unsigned TICK_MS       = 20;
    localparam int unsigned TICKS_PER_SEC = 1000 / TICK_MS;
    localparam int unsigned ACC_W         = 10;
    localparam int unsigned ACC_MAX       = (1 << ACC_W) - 1;

    // Beeper sequence
    localparam int unsigned BEEP_W        = 8;
    localparam int unsigned BEEP_PRESCALE = 20;
    localparam int unsigned BEEP_PHASES   = 25;

    // Field widths
    localparam int unsigned SEC_W    = 16;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned MISSED_W = 8;
    localparam int unsigned TONE_W   = 2;

    // Stream and configuration port widths
    localparam int unsigned S_DATA_W  = 16;
    localparam int unsigned M_DATA_W  = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // Mode register bits
    localparam int unsigned MODE_ALARM_BIT = 0;
    localparam int unsigned MODE_DOWN_BIT  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'b1;

    // Tone change codes
    localparam logic [TONE_W-1:0] TONE_NONE = 2'd0;
    localparam logic [TONE_W-1:0] TONE_ON   = 2'd1;
    localparam logic [TONE_W-1:0] TONE_OFF  = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_INIT    = 3'd1,
        CMD_START   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_SILENCE = 3'd4
    } cmd_t;

    // Timer state carried between the state register and the step logic
    typedef struct packed {
        logic [SEC_W-1:0]  seconds;
        logic [ACC_W-1:0]  acc;
        logic              running;
        logic              beeping;
        logic [BEEP_W-1:0] prescale;
        logic [BEEP_W-1:0] phase;
    } tmr_state_t;

    // Configuration seen by the step logic
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SEC_W-1:0]  target;
    } tmr_cfg_t;

endpackage

FILE: rtl/up_down_seconds_timer_with_beeper_core.sv
// Up/down seconds timer with alarm beeper: state, result register and ports.
//
// Every command item returns exactly one result item. An item is taken in the
// cycle it arrives and its result shows on the m_ side in the next cycle, so
// the block sustains one item per clock; s_tready only drops while a result
// is held and m_tready is low. The command is applied by combinational logic
// between the state register and the result register. Configuration writes
// are always accepted (cfg_ready is tied high) and should be issued only
// while no command is in flight. Index 0 is the mode (bit 0 alarm at target,
// bit 1 count down), index 1 the unsigned target seconds.
module up_down_seconds_timer_with_beeper_core
    import udtmr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // command items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [2:0] command, [10:3] missed_ticks, rest zero
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [15:0] seconds_value, [25:16] sub_ticks,
                                             // [26] is_counting, [27] beeper_active,
                                             // [29:28] tone_change, rest zero
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tmr_state_t          state_reg, state_next;
    tmr_cfg_t            cfg_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [TONE_W-1:0]   tone;
    logic                s_accept;
    logic [CMD_W-1:0]    in_command;
    logic [MISSED_W-1:0] in_missed;

    assign in_command = s_tdata[CMD_W-1:0];
    assign in_missed  = s_tdata[CMD_W +: MISSED_W];
    assign s_tready   = !m_valid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    udtmr_step u_step (
        .cur          (state_reg),
        .cfg          (cfg_reg),
        .command      (in_command),
        .missed_ticks (in_missed),
        .nxt          (state_next),
        .tone         (tone)
    );

    // Pack the result item
    assign m_data_next = {(M_DATA_W-SEC_W-ACC_W-2-TONE_W)'(0), tone,
                          state_next.beeping, state_next.running,
                          state_next.acc, state_next.seconds};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MODE:   cfg_reg.mode   <= cfg_data[MODE_W-1:0];
                REG_TARGET: cfg_reg.target <= cfg_data[SEC_W-1:0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Advance the timer state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // An accepted item always leaves a result waiting
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted item produced no result");

    // The tone code never takes the unused value
    a_tone_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[SEC_W+ACC_W+2 +: TONE_W] != 2'd3))
        else $error("invalid tone code");

    // A start command leaves the timer running
    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_command == CMD_START)) |=> state_reg.running)
        else $error("start did not set running");

    // Only a tick can change the tone
    a_tone_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_command != CMD_TICK)) |=>
            (m_data_reg[SEC_W+ACC_W+2 +: TONE_W] == TONE_NONE))
        else $error("tone change on a non-tick command");

    // Reported state matches the stored state
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_data_reg[SEC_W-1:0] == state_reg.seconds)
                     && (m_data_reg[SEC_W +: ACC_W] == state_reg.acc))
        else $error("result does not match timer state");

endmodule

FILE: rtl/udtmr_step.sv
// Next-state logic of the timer: applies one command to the current state.
module udtmr_step
    import udtmr_pkg::*;
(
    input  tmr_state_t           cur,
    input  tmr_cfg_t             cfg,
    input  logic [CMD_W-1:0]     command,
    input  logic [MISSED_W-1:0]  missed_ticks,
    output tmr_state_t           nxt,
    output logic [TONE_W-1:0]    tone
);

    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;
    logic              sec_step;
    logic [SEC_W-1:0]  sec_run;
    logic [ACC_W-1:0]  acc_run;
    logic              alarm_hit;
    logic              down_zero;
    tmr_state_t        tk;
    logic [BEEP_W-1:0] phase_inc;
    logic              beep_edge;
    logic [TONE_W-1:0] tick_tone;

    // Accumulate ticks, saturate, take at most one second
    always_comb begin
        acc_sum  = {1'b0, cur.acc} + (ACC_W+1)'(missed_ticks) + (ACC_W+1)'(1);
        acc_sat  = (acc_sum > (ACC_W+1)'(ACC_MAX)) ? ACC_W'(ACC_MAX) : acc_sum[ACC_W-1:0];
        sec_step = (acc_sat >= ACC_W'(TICKS_PER_SEC));
        acc_run  = sec_step ? (acc_sat - ACC_W'(TICKS_PER_SEC)) : acc_sat;
        if (!sec_step) begin
            sec_run = cur.seconds;
        end else if (cfg.mode[MODE_DOWN_BIT]) begin
            sec_run = cur.seconds - SEC_W'(1);
        end else begin
            sec_run = cur.seconds + SEC_W'(1);
        end
        alarm_hit = cfg.mode[MODE_ALARM_BIT] && (sec_run == cfg.target)
                    && (sec_run != '0);
        down_zero = cfg.mode[MODE_DOWN_BIT] && (sec_run == '0);
    end

    // Tick: counting part, then beeper part
    always_comb begin
        tk = cur;
        if (cur.running) begin
            tk.seconds = sec_run;
            tk.acc     = acc_run;
            if (alarm_hit || down_zero) begin
                tk.beeping  = 1'b1;
                tk.phase    = '0;
                tk.prescale = '0;
            end
            if (down_zero) begin
                tk.running = 1'b0;
                tk.seconds = cfg.target;
                tk.acc     = '0;
            end
        end
        phase_inc = tk.phase + BEEP_W'(1);
        beep_edge = (tk.prescale == BEEP_W'(BEEP_PRESCALE)) || (tk.prescale == '0);
        tick_tone = TONE_NONE;
        if (tk.beeping) begin
            if (beep_edge) begin
                tk.prescale = '0;
                tk.phase    = phase_inc;
                tick_tone   = phase_inc[0] ? TONE_OFF : TONE_ON;
            end
            if (tk.phase == BEEP_W'(BEEP_PHASES)) begin
                tk.beeping = 1'b0;
            end
            tk.prescale = tk.prescale + BEEP_W'(1);
        end
    end

    // Decode the command
    always_comb begin
        nxt  = cur;
        tone = TONE_NONE;
        unique case (command)
            CMD_TICK: begin
                nxt  = tk;
                tone = tick_tone;
            end
            CMD_INIT: begin
                nxt.seconds = cfg.mode[MODE_DOWN_BIT] ? cfg.target : '0;
                nxt.acc     = '0;
                nxt.running = 1'b0;
                nxt.beeping = 1'b0;
            end
            CMD_START:   nxt.running = 1'b1;
            CMD_STOP:    nxt.running = 1'b0;
            CMD_SILENCE: nxt.beeping = 1'b0;
            default:     nxt = cur;
        endcase
    end

endmodule
